// ----- design/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bitmap slot allocator: pool geometry,
// command codes and result status codes.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // Pool geometry (fixed by the 7-bit slot index and 8-bit count fields)
  localparam int SLOTS    = 128;
  localparam int SLOT_W   = 7;
  localparam int CNT_W    = 8;

  // Two-level first-free search: groups of eight slots
  localparam int GRP_SIZE = 8;
  localparam int GRP_W    = 3;
  localparam int GRPS     = SLOTS / GRP_SIZE;
  localparam int GRPS_W   = SLOT_W - GRP_W;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(128);

  // Command codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

endpackage

// ----- design/bitmap_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// Slot pool allocator: grants the lowest free slot below the configured
// limit, releases named slots, and reports the free count with each result.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  request  | start / busy            | in_command, in_slot_to_free
//  result   | out_valid (strobe)      | out_granted_slot, out_status,
//           |                         | out_free_count
//  config   | cfg_wr_en               | cfg_wr_data (slot limit)
//
//  A request is taken on every clock edge with start high and busy low; busy
//  is high only in the cycle after reset. Each request yields one result,
//  registered through the request register and then the result register, so
//  one request per cycle is sustained. The first-free search is a two-level
//  priority encode over the 128-bit used map, combinational alongside the
//  map update, so back-to-back requests see each other's effect. Reset clears
//  the used map and the used count and sets the limit to 128. The result
//  strobe cannot be stalled.
//
module bitmap_slot_allocator_top
  import bsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // request
  input  logic              start,
  output logic              busy,
  input  logic              in_command,
  input  logic [SLOT_W-1:0] in_slot_to_free,
  // result
  output logic              out_valid,
  output logic [SLOT_W-1:0] out_granted_slot,
  output logic [1:0]        out_status,
  output logic [CNT_W-1:0]  out_free_count,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data
);

  // State
  logic              busy_r;
  logic [CNT_W-1:0]  limit_cfg_r;
  logic [SLOTS-1:0]  used_map_r,   used_map_nxt;
  logic [CNT_W-1:0]  used_count_r, used_count_nxt;

  // Request register
  logic              req_vld_r;
  cmd_t              req_cmd_r;
  logic [SLOT_W-1:0] req_idx_r;

  // Result register
  logic              out_vld_r;
  logic [SLOT_W-1:0] out_slot_r,  out_slot_nxt;
  status_t           out_st_r,    out_st_nxt;
  logic [CNT_W-1:0]  out_free_r,  out_free_nxt;

  // Search signals
  logic [CNT_W-1:0]  lim;
  logic [SLOTS-1:0]  lim_mask;
  logic [SLOTS-1:0]  free_vec;
  logic [GRPS-1:0]   grp_any;
  logic [GRP_W-1:0]  grp_idx [GRPS];
  logic [GRPS_W-1:0] grp_sel;
  logic              found;
  logic [SLOT_W-1:0] first_free;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      req_vld_r    <= 1'b0;
      out_vld_r    <= 1'b0;
      limit_cfg_r  <= LIMIT_RST;
      used_map_r   <= '0;
      used_count_r <= '0;
    end else begin
      busy_r       <= 1'b0;
      req_vld_r    <= start && !busy_r;
      out_vld_r    <= req_vld_r;
      used_map_r   <= used_map_nxt;
      used_count_r <= used_count_nxt;
      if (cfg_wr_en) begin
        limit_cfg_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_cmd_r <= cmd_t'(in_command);
    req_idx_r <= in_slot_to_free;
    if (req_vld_r) begin
      out_slot_r <= out_slot_nxt;
      out_st_r   <= out_st_nxt;
      out_free_r <= out_free_nxt;
    end
  end

  // Effective limit saturates at the pool size
  assign lim = (limit_cfg_r > SLOTS_CNT) ? SLOTS_CNT : limit_cfg_r;

  // Allocatable slots: free and below the limit
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      lim_mask[i] = (CNT_W'(i) < lim);
    end
  end
  assign free_vec = ~used_map_r & lim_mask;

  // First level: lowest free slot within each group of eight
  always_comb begin
    for (int g = 0; g < GRPS; g++) begin
      grp_any[g] = |free_vec[g*GRP_SIZE +: GRP_SIZE];
      grp_idx[g] = '0;
      for (int j = GRP_SIZE - 1; j >= 0; j--) begin
        if (free_vec[g*GRP_SIZE + j]) begin
          grp_idx[g] = GRP_W'(j);
        end
      end
    end
  end

  // Second level: lowest group with a free slot
  always_comb begin
    grp_sel = '0;
    for (int g = GRPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = GRPS_W'(g);
      end
    end
  end

  assign found      = |grp_any;
  assign first_free = {grp_sel, grp_idx[grp_sel]};

  // Command execution and map update
  always_comb begin
    used_map_nxt   = used_map_r;
    used_count_nxt = used_count_r;
    out_slot_nxt   = '0;
    out_st_nxt     = ST_OK;
    if (req_vld_r) begin
      unique case (req_cmd_r)
        CMD_ALLOC: begin
          if (found) begin
            used_map_nxt[first_free] = 1'b1;
            used_count_nxt           = used_count_r + 1'b1;
            out_slot_nxt             = first_free;
          end else begin
            out_st_nxt = ST_FULL;
          end
        end
        CMD_FREE: begin
          if ({1'b0, req_idx_r} >= lim) begin
            out_st_nxt = ST_RANGE;
          end else if (!used_map_r[req_idx_r]) begin
            out_st_nxt = ST_NOT_ALLOC;
          end else begin
            used_map_nxt[req_idx_r] = 1'b0;
            if (used_count_r != '0) begin
              used_count_nxt = used_count_r - 1'b1;
            end
          end
        end
        default: begin
          out_st_nxt = ST_OK;
        end
      endcase
    end
  end

  // Free count after this command
  assign out_free_nxt = (lim > used_count_nxt) ? (lim - used_count_nxt) : '0;

  // Outputs
  assign busy             = busy_r;
  assign out_valid        = out_vld_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_st_r;
  assign out_free_count   = out_free_r;

endmodule

// ----- design/bsa_checker.sv -----
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks for the slot allocator: request/result pairing and the
// status codes each command can produce. Bound to the top level.
// ----------------------------------------------------------------------------
module bsa_checker
  import bsa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_command,
  input logic              out_valid,
  input logic [SLOT_W-1:0] out_granted_slot,
  input logic [1:0]        out_status,
  input logic [CNT_W-1:0]  out_free_count
);

  // Every taken request yields a result through the request and result registers
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("request without result");

  // No result appears without a matching taken request
  a_result_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without request");

  // Allocate can only succeed or report full; full means no free slot
  a_alloc_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_command, 2) == CMD_ALLOC) |->
      ((out_status == ST_OK) ||
       (out_status == ST_FULL && out_free_count == '0 && out_granted_slot == '0)))
    else $error("bad allocate result");

  // Free never reports full and never grants a slot
  a_free_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_command, 2) == CMD_FREE) |->
      (out_status != ST_FULL && out_granted_slot == '0))
    else $error("bad free result");

endmodule

bind bitmap_slot_allocator_top bsa_checker u_bsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_command       (in_command),
  .out_valid        (out_valid),
  .out_granted_slot (out_granted_slot),
  .out_status       (out_status),
  .out_free_count   (out_free_count)
);
